[sv/twi_pkg.sv]
package twi_pkg;

   // field widths
   localparam int KIND_W   = 2;
   localparam int CELL_W   = 10;
   localparam int HEAD_W   = 3;
   localparam int TIME_W   = 32;
   localparam int FRAC_W   = 8;
   localparam int FIX_W    = CELL_W + FRAC_W;
   localparam int SEG_W    = 7;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 1;

   // interpolation product and quotient
   localparam int PROD_W = FIX_W + TIME_W;
   localparam int QUO_W  = FIX_W;

   // request kinds; any kind with the high bit set is a query
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BEFORE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_PAST   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_MOVING = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 1'b1;

   // one waypoint table entry
   typedef struct packed {
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic [HEAD_W-1:0] heading;
      logic [TIME_W-1:0] stamp;
   } wp_type;

endpackage

[sv/twi_div.sv]
// Restoring divider for a quotient known to fit in QUO_W bits:
// one quotient bit per cycle, done pulses as the last bit is registered.
module twi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [twi_pkg::PROD_W-1:0]    dividend,
   input  logic [twi_pkg::TIME_W-1:0]    divisor,
   output logic                          done,
   output logic [twi_pkg::QUO_W-1:0]     quotient
);

   localparam int STEP_W = $clog2(twi_pkg::QUO_W);

   logic                          busy_ff;
   logic                          done_ff;
   logic [STEP_W-1:0]             step_ff;
   logic [twi_pkg::TIME_W-1:0]    rem_ff;
   logic [twi_pkg::QUO_W-1:0]     low_ff;
   logic [twi_pkg::TIME_W-1:0]    div_ff;

   logic [twi_pkg::TIME_W:0]      trial;
   logic [twi_pkg::TIME_W:0]      diff;
   logic                          fits;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      trial = {rem_ff, low_ff[twi_pkg::QUO_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
   end

   // sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(twi_pkg::QUO_W - 1);
         end else if (busy_ff) begin
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   // load the operands, then shift quotient bits in as dividend bits go out
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[twi_pkg::PROD_W-1:twi_pkg::QUO_W];
         low_ff <= dividend[twi_pkg::QUO_W-1:0];
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[twi_pkg::TIME_W-1:0] : trial[twi_pkg::TIME_W-1:0];
         low_ff <= {low_ff[twi_pkg::QUO_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

[sv/timed_waypoint_interpolator_core.sv]
// Channel   Ports                          Handshake
// request   req_kind .. req_stamp          taken when start high and busy low
// response  rsp_status .. rsp_facing       rsp_valid high for one cycle
// config    csr_index, csr_wdata           written when csr_we high
//
// Clear and append finish at once: the response word follows in the next cycle
// and busy stays low. A query reads the table through one registered port: an
// empty table answers next cycle; otherwise the query checks the first entry,
// then scans forward from the remembered segment, and a hit runs the 18-step
// shared divider once per axis. Reset is synchronous and clears the count, the
// remembered segment and the start point. The receiver cannot stall: every
// response word is shown for exactly one cycle.
module timed_waypoint_interpolator_core #(
   parameter int MAX_WAYPOINTS = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [twi_pkg::KIND_W-1:0]        req_kind,
   input  logic [twi_pkg::CELL_W-1:0]        req_cell_x,
   input  logic [twi_pkg::CELL_W-1:0]        req_cell_y,
   input  logic [twi_pkg::HEAD_W-1:0]        req_heading,
   input  logic [twi_pkg::TIME_W-1:0]        req_stamp,
   output logic                              rsp_valid,
   output logic [twi_pkg::STATUS_W-1:0]      rsp_status,
   output logic [twi_pkg::SEG_W-1:0]         rsp_segment,
   output logic [twi_pkg::FIX_W-1:0]         rsp_pos_x,
   output logic [twi_pkg::FIX_W-1:0]         rsp_pos_y,
   output logic [twi_pkg::HEAD_W-1:0]        rsp_facing,
   input  logic                              csr_we,
   input  logic [twi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [twi_pkg::FIX_W-1:0]         csr_wdata
);

   localparam int IDX_W = $clog2(MAX_WAYPOINTS);
   localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FIRST  = 4'd1;
   localparam logic [3:0] S_HEAD1  = 4'd2;
   localparam logic [3:0] S_SRCH_A = 4'd3;
   localparam logic [3:0] S_SRCH_B = 4'd4;
   localparam logic [3:0] S_LAST   = 4'd5;
   localparam logic [3:0] S_PREP   = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;

   localparam int FIX_W  = twi_pkg::FIX_W;
   localparam int TIME_W = twi_pkg::TIME_W;

   // low segment bits of a table index
   function automatic logic [twi_pkg::SEG_W-1:0] seg_of(input logic [CNT_W-1:0] v);
      logic [CNT_W+twi_pkg::SEG_W-1:0] w;
      w = {{twi_pkg::SEG_W{1'b0}}, v};
      return w[twi_pkg::SEG_W-1:0];
   endfunction

   // cell coordinate to fixed point
   function automatic logic [twi_pkg::FIX_W-1:0] fix_of(input logic [twi_pkg::CELL_W-1:0] c);
      return {c, {twi_pkg::FRAC_W{1'b0}}};
   endfunction

   twi_pkg::wp_type             mem [MAX_WAYPOINTS];
   twi_pkg::wp_type             rd_data_ff;
   logic [IDX_W-1:0]            rd_addr;
   logic                        wr_en;

   logic [3:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            sstart_ff, sstart_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic [TIME_W-1:0]           t_ff, t_in;
   twi_pkg::wp_type             prev_ff, prev_in;
   twi_pkg::wp_type             cur_ff, cur_in;
   logic                        axis_ff, axis_in;
   logic [TIME_W-1:0]           dt_ff, dt_in;
   logic [TIME_W-1:0]           mt_ff, mt_in;
   logic                        neg_ff, neg_in;
   logic [FIX_W-1:0]            mag_ff, mag_in;
   logic [FIX_W-1:0]            base_ff, base_in;
   logic [FIX_W-1:0]            startx_ff, starty_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [twi_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [twi_pkg::SEG_W-1:0]   rsp_segment_ff, rsp_segment_in;
   logic [FIX_W-1:0]            rsp_pos_x_ff, rsp_pos_x_in;
   logic [FIX_W-1:0]            rsp_pos_y_ff, rsp_pos_y_in;
   logic [twi_pkg::HEAD_W-1:0]  rsp_facing_ff, rsp_facing_in;

   logic                        accept;
   logic [CNT_W-1:0]            last;
   logic [CNT_W-1:0]            idx_next;
   logic                        hit;
   logic [FIX_W-1:0]            ax_start;
   logic [FIX_W-1:0]            ax_end;
   logic [FIX_W:0]              ax_len;
   logic [FIX_W-1:0]            ax_pos;

   logic                        div_start;
   logic                        div_done;
   logic [twi_pkg::PROD_W-1:0]  product;
   logic [twi_pkg::QUO_W-1:0]   quotient;

   assign accept   = start && (state_ff == S_IDLE);
   assign last     = count_ff - 1'b1;
   assign idx_next = idx_ff + 1'b1;
   assign hit      = (t_ff >= prev_ff.stamp) && (t_ff < rd_data_ff.stamp);

   // axis operands for the segment in hand
   always_comb begin
      if (axis_ff) begin
         ax_start = (idx_ff == '0) ? starty_ff : fix_of(prev_ff.cell_y);
         ax_end   = fix_of(cur_ff.cell_y);
      end else begin
         ax_start = (idx_ff == '0) ? startx_ff : fix_of(prev_ff.cell_x);
         ax_end   = fix_of(cur_ff.cell_x);
      end
      ax_len = {1'b0, ax_end} - {1'b0, ax_start};
      ax_pos = neg_ff ? (base_ff - quotient) : (base_ff + quotient);
   end

   assign product = {{TIME_W{1'b0}}, mag_ff} * {{FIX_W{1'b0}}, mt_ff};

   // sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      sstart_in      = sstart_ff;
      idx_in         = idx_ff;
      t_in           = t_ff;
      prev_in        = prev_ff;
      cur_in         = cur_ff;
      axis_in        = axis_ff;
      dt_in          = dt_ff;
      mt_in          = mt_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      base_in        = base_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_segment_in = rsp_segment_ff;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;
      rsp_facing_in  = rsp_facing_ff;
      rd_addr        = '0;
      wr_en          = 1'b0;
      div_start      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               t_in           = req_stamp;
               rsp_status_in  = twi_pkg::STATUS_OK;
               rsp_segment_in = '0;
               rsp_pos_x_in   = '0;
               rsp_pos_y_in   = '0;
               rsp_facing_in  = '0;
               if (req_kind == twi_pkg::KIND_CLEAR) begin
                  count_in     = '0;
                  sstart_in    = '0;
                  rsp_valid_in = 1'b1;
               end else if (req_kind == twi_pkg::KIND_APPEND) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff >= CNT_W'(MAX_WAYPOINTS)) begin
                     rsp_status_in = twi_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  rsp_status_in = twi_pkg::STATUS_EMPTY;
                  rsp_valid_in  = 1'b1;
               end else begin
                  state_in = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            if (t_ff < rd_data_ff.stamp) begin
               rsp_status_in = twi_pkg::STATUS_BEFORE;
               rsp_pos_x_in  = fix_of(rd_data_ff.cell_x);
               rsp_pos_y_in  = fix_of(rd_data_ff.cell_y);
               if (count_ff >= CNT_W'(2)) begin
                  rd_addr  = IDX_W'(1);
                  state_in = S_HEAD1;
               end else begin
                  rsp_facing_in = rd_data_ff.heading;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (CNT_W'(sstart_ff) >= last) begin
               rd_addr  = last[IDX_W-1:0];
               state_in = S_LAST;
            end else begin
               idx_in   = CNT_W'(sstart_ff);
               rd_addr  = sstart_ff;
               state_in = S_SRCH_A;
            end
         end
         S_HEAD1: begin
            rsp_facing_in = rd_data_ff.heading;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         S_SRCH_A: begin
            prev_in  = rd_data_ff;
            rd_addr  = idx_next[IDX_W-1:0];
            state_in = S_SRCH_B;
         end
         S_SRCH_B: begin
            if (hit) begin
               cur_in   = rd_data_ff;
               dt_in    = rd_data_ff.stamp - prev_ff.stamp;
               mt_in    = t_ff - prev_ff.stamp;
               axis_in  = 1'b0;
               state_in = S_PREP;
            end else if (idx_next < last) begin
               // advance one segment, reusing the upper entry
               idx_in  = idx_next;
               prev_in = rd_data_ff;
               rd_addr = idx_next[IDX_W-1:0] + 1'b1;
            end else begin
               rd_addr  = last[IDX_W-1:0];
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            rsp_status_in  = twi_pkg::STATUS_PAST;
            rsp_segment_in = seg_of(last);
            rsp_pos_x_in   = fix_of(rd_data_ff.cell_x);
            rsp_pos_y_in   = fix_of(rd_data_ff.cell_y);
            rsp_facing_in  = rd_data_ff.heading;
            rsp_valid_in   = 1'b1;
            sstart_in      = '0;
            state_in       = S_IDLE;
         end
         S_PREP: begin
            neg_in  = ax_len[FIX_W];
            mag_in  = ax_len[FIX_W] ? (~ax_len[FIX_W-1:0] + 1'b1) : ax_len[FIX_W-1:0];
            base_in = ax_start;
            if (!axis_ff) begin
               rsp_facing_in = (mt_ff < (dt_ff >> 1)) ? prev_ff.heading : cur_ff.heading;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               if (!axis_ff) begin
                  rsp_pos_x_in = ax_pos;
                  axis_in      = 1'b1;
                  state_in     = S_PREP;
               end else begin
                  rsp_pos_y_in   = ax_pos;
                  rsp_status_in  = twi_pkg::STATUS_MOVING;
                  rsp_segment_in = seg_of(idx_ff);
                  rsp_valid_in   = 1'b1;
                  sstart_in      = idx_ff[IDX_W-1:0];
                  state_in       = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // waypoint table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= '{cell_x:  req_cell_x,
                                      cell_y:  req_cell_y,
                                      heading: req_heading,
                                      stamp:   req_stamp};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control state and start point
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sstart_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         startx_ff    <= '0;
         starty_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sstart_ff    <= sstart_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               twi_pkg::CSR_START_X: startx_ff <= csr_wdata;
               twi_pkg::CSR_START_Y: starty_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // working registers and response word
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      t_ff           <= t_in;
      prev_ff        <= prev_in;
      cur_ff         <= cur_in;
      axis_ff        <= axis_in;
      dt_ff          <= dt_in;
      mt_ff          <= mt_in;
      neg_ff         <= neg_in;
      mag_ff         <= mag_in;
      base_ff        <= base_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_segment_ff <= rsp_segment_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
      rsp_facing_ff  <= rsp_facing_in;
   end

   twi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (dt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_segment = rsp_segment_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = rsp_pos_y_ff;
   assign rsp_facing  = rsp_facing_ff;

`ifndef SYNTHESIS
   // the fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_WAYPOINTS))
      else $error("waypoint count beyond table depth");

   // a query on a filled table reads the table before answering
   a_query_wait: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind[1] && (count_ff != '0)) |=> !rsp_valid_ff)
      else $error("query answered without a table read");

   // the divider finishes only while the sequencer waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider done outside the divide wait");

   // a moving word comes only out of the divide wait
   a_moving_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == twi_pkg::STATUS_MOVING)) |->
      ($past(state_ff) == S_DIV))
      else $error("moving word without interpolation");
`endif

endmodule

[dv/tb_top.sv]
module tb_top;
   import twi_pkg::*;

   localparam int MAX_WP      = 128;
   localparam int WORD_TARGET = 950;
   localparam int CYCLE_LIMIT = 1_000_000;

   // any kind with the high bit set is decoded as a query
   localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY_HI = 2'd3;
   localparam logic [FIX_W-1:0]  FIX_MAX       = '1;
   localparam logic [TIME_W-1:0] TIME_MAX      = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SEG_W-1:0]    segment;
      logic [FIX_W-1:0]    pos_x;
      logic [FIX_W-1:0]    pos_y;
      logic [HEAD_W-1:0]   facing;
   } position_word_t;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 start       = 1'b0;
   logic                 busy;
   logic [KIND_W-1:0]    req_kind    = '0;
   logic [CELL_W-1:0]    req_cell_x  = '0;
   logic [CELL_W-1:0]    req_cell_y  = '0;
   logic [HEAD_W-1:0]    req_heading = '0;
   logic [TIME_W-1:0]    req_stamp   = '0;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SEG_W-1:0]     rsp_segment;
   logic [FIX_W-1:0]     rsp_pos_x;
   logic [FIX_W-1:0]     rsp_pos_y;
   logic [HEAD_W-1:0]    rsp_facing;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [FIX_W-1:0]     csr_wdata   = '0;

   // local copy of the waypoint table and the block's registers
   logic [CELL_W-1:0] track_x    [MAX_WP];
   logic [CELL_W-1:0] track_y    [MAX_WP];
   logic [HEAD_W-1:0] track_head [MAX_WP];
   logic [TIME_W-1:0] track_time [MAX_WP];
   int unsigned       track_count = 0;
   int unsigned       resume_seg  = 0;
   logic [FIX_W-1:0]  origin_x    = '0;
   logic [FIX_W-1:0]  origin_y    = '0;

   position_word_t awaited_positions[$];
   int             error_count   = 0;
   int             checked_words = 0;
   int             words_sent    = 0;
   int             cycle_count   = 0;
   int             burst_left    = 3;
   bit             steady_sender = 1'b0;

   timed_waypoint_interpolator_core #(
      .MAX_WAYPOINTS(MAX_WP)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_kind    (req_kind),
      .req_cell_x  (req_cell_x),
      .req_cell_y  (req_cell_y),
      .req_heading (req_heading),
      .req_stamp   (req_stamp),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_segment (rsp_segment),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_facing  (rsp_facing),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // start + trunc(len * num / den), truncating toward zero
   function automatic logic [FIX_W-1:0] blend_axis(input logic [FIX_W-1:0] from_p,
                                                   input logic [FIX_W-1:0] to_p,
                                                   input logic [TIME_W-1:0] num,
                                                   input logic [TIME_W-1:0] den);
      longint from_v;
      longint to_v;
      longint num_v;
      longint den_v;
      longint len;
      longint mag;
      longint q;
      longint sum;
      from_v = from_p;
      to_v   = to_p;
      num_v  = num;
      den_v  = den;
      len    = to_v - from_v;
      mag    = (len < 0) ? -len : len;
      q      = (mag * num_v) / den_v;
      sum    = (len < 0) ? from_v - q : from_v + q;
      return sum[FIX_W-1:0];
   endfunction

   // work out the position word for one accepted item and advance the table
   function automatic position_word_t track_position(input logic [KIND_W-1:0] kind,
                                                     input logic [CELL_W-1:0] cx,
                                                     input logic [CELL_W-1:0] cy,
                                                     input logic [HEAD_W-1:0] hd,
                                                     input logic [TIME_W-1:0] t);
      position_word_t w;
      int unsigned    last_idx;
      int unsigned    seg;
      int unsigned    i;
      bit             hit;
      logic [TIME_W-1:0] span_t;
      logic [TIME_W-1:0] into_t;
      logic [FIX_W-1:0]  from_x;
      logic [FIX_W-1:0]  from_y;
      w = '0;
      if (kind == KIND_CLEAR) begin
         track_count = 0;
         resume_seg  = 0;
         w.status    = STATUS_OK;
      end else if (kind == KIND_APPEND) begin
         if (track_count >= MAX_WP) begin
            w.status = STATUS_FULL;
         end else begin
            track_x[track_count]    = cx;
            track_y[track_count]    = cy;
            track_head[track_count] = hd;
            track_time[track_count] = t;
            track_count++;
            w.status = STATUS_OK;
         end
      end else if (track_count == 0) begin
         w.status = STATUS_EMPTY;
      end else if (t < track_time[0]) begin
         w.status = STATUS_BEFORE;
         w.pos_x  = {track_x[0], {FRAC_W{1'b0}}};
         w.pos_y  = {track_y[0], {FRAC_W{1'b0}}};
         w.facing = (track_count >= 2) ? track_head[1] : track_head[0];
      end else begin
         // scan forward from the remembered segment
         last_idx = track_count - 1;
         hit      = 1'b0;
         seg      = 0;
         for (i = resume_seg; i < last_idx; i++) begin
            if (!hit && t >= track_time[i] && t < track_time[i+1]) begin
               hit = 1'b1;
               seg = i;
            end
         end
         if (!hit) begin
            w.status   = STATUS_PAST;
            w.segment  = SEG_W'(last_idx);
            w.pos_x    = {track_x[last_idx], {FRAC_W{1'b0}}};
            w.pos_y    = {track_y[last_idx], {FRAC_W{1'b0}}};
            w.facing   = track_head[last_idx];
            resume_seg = 0;
         end else begin
            span_t     = track_time[seg+1] - track_time[seg];
            into_t     = t - track_time[seg];
            from_x     = (seg == 0) ? origin_x : {track_x[seg], {FRAC_W{1'b0}}};
            from_y     = (seg == 0) ? origin_y : {track_y[seg], {FRAC_W{1'b0}}};
            w.status   = STATUS_MOVING;
            w.segment  = SEG_W'(seg);
            w.pos_x    = blend_axis(from_x, {track_x[seg+1], {FRAC_W{1'b0}}}, into_t, span_t);
            w.pos_y    = blend_axis(from_y, {track_y[seg+1], {FRAC_W{1'b0}}}, into_t, span_t);
            w.facing   = (t < track_time[seg] + span_t / 2) ? track_head[seg]
                                                            : track_head[seg+1];
            resume_seg = seg;
         end
      end
      return w;
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("word %0d %s: got %0d, expected %0d",
                              checked_words, name, got, want));
   endtask

   // compare each result word with the oldest one awaited
   always @(negedge clock) begin : check_words
      position_word_t want;
      if (!reset && rsp_valid) begin
         if (awaited_positions.size() == 0) begin
            flag_error($sformatf("unexpected word: status %0d segment %0d",
                                 rsp_status, rsp_segment));
         end else begin
            want = awaited_positions.pop_front();
            check_field("status", rsp_status, want.status);
            check_field("segment", rsp_segment, want.segment);
            check_field("pos_x", rsp_pos_x, want.pos_x);
            check_field("pos_y", rsp_pos_y, want.pos_y);
            check_field("facing", rsp_facing, want.facing);
            checked_words++;
         end
      end
   end

   // unless the sender is steady, drop start for a random gap once the current burst is spent
   task automatic pace_sender();
      if (!steady_sender) begin
         burst_left--;
         if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 6))
               @(posedge clock);
            burst_left = $urandom_range(1, 10);
         end
      end
   endtask

   // present one word and hold it until the block takes it
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CELL_W-1:0] cx,
                            input logic [CELL_W-1:0] cy, input logic [HEAD_W-1:0] hd,
                            input logic [TIME_W-1:0] t);
      req_kind    <= kind;
      req_cell_x  <= cx;
      req_cell_y  <= cy;
      req_heading <= hd;
      req_stamp   <= t;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      awaited_positions.push_back(track_position(kind, cx, cy, hd, t));
      words_sent++;
      pace_sender();
   endtask

   // hold off until every awaited word has come back
   task automatic settle_track();
      start <= 1'b0;
      while (awaited_positions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_origin(input logic [CSR_IDX_W-1:0] idx, input logic [FIX_W-1:0] value);
      settle_track();
      csr_index <= idx;
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_START_X)
         origin_x = value;
      else
         origin_y = value;
   endtask

   // choose a query time, mostly walking forward through the segments
   function automatic logic [TIME_W-1:0] pick_query_time(inout int cursor);
      int unsigned last_idx;
      int unsigned pick;
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] t1;
      logic [TIME_W-1:0] span_t;
      logic [TIME_W-1:0] off;
      last_idx = track_count - 1;
      pick     = $urandom_range(0, 99);
      if (pick < 8)
         return (track_time[0] == 0) ? '0 : $urandom_range(0, track_time[0] - 1);
      if (pick < 16) begin
         cursor = 0;
         return $urandom_range(track_time[last_idx], TIME_MAX);
      end
      if (pick < 22)
         return $urandom;
      if (pick < 30)
         cursor = $urandom_range(0, cursor);
      else if ($urandom_range(0, 2) == 0 && cursor + 1 < last_idx)
         cursor = $urandom_range(cursor + 1,
                                 (cursor + 4 < last_idx) ? cursor + 4 : last_idx - 1);
      t0 = track_time[cursor];
      t1 = track_time[cursor+1];
      if (t1 <= t0)
         return t0;
      span_t = t1 - t0;
      // land on the segment ends and either side of the half time
      case ($urandom_range(0, 4))
         0: off = 0;
         1: off = span_t - 1;
         2: off = span_t / 2;
         3: off = (span_t >= 2) ? span_t / 2 - 1 : 0;
         default: off = $urandom_range(0, span_t - 1);
      endcase
      return t0 + off;
   endfunction

   // clear, lay down a rising track with random content, then query along it
   task automatic run_track(input int points, input int queries, input bit pause_mid);
      logic [TIME_W-1:0] gaps [MAX_WP+2];
      logic [TIME_W-1:0] span_total;
      logic [TIME_W-1:0] stamp_v;
      int unsigned       step_cap;
      int                cursor;
      int                k;
      case ($urandom_range(0, 3))
         0: step_cap = 4;
         1: step_cap = 1000;
         2: step_cap = 1 << 20;
         default: step_cap = 1 << 24;
      endcase
      span_total = 0;
      for (k = 1; k < points; k++) begin
         gaps[k] = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step_cap);
         span_total += gaps[k];
      end
      stamp_v = $urandom_range(0, TIME_MAX - span_total);
      send_word(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
      for (k = 0; k < points; k++) begin
         if (k > 0)
            stamp_v += gaps[k];
         // now and then break the rising order
         send_word(KIND_APPEND, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 7), ($urandom_range(0, 19) == 0) ? $urandom : stamp_v);
      end
      if (pause_mid || $urandom_range(0, 5) == 0)
         settle_track();
      cursor = 0;
      for (k = 0; k < queries; k++) begin
         if ($urandom_range(0, 24) == 0)
            send_word(KIND_APPEND, $urandom, $urandom, $urandom, $urandom);
         else
            send_word(($urandom_range(0, 7) == 0) ? KIND_QUERY_HI : KIND_QUERY,
                      $urandom, $urandom, $urandom, pick_query_time(cursor));
      end
   endtask

   task automatic test_empty_table();
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd0);
      send_word(KIND_QUERY_HI, 10'd1023, 10'd1023, 3'd7, TIME_MAX);
      send_word(KIND_CLEAR, 10'd1023, 10'd1023, 3'd7, TIME_MAX);
   endtask

   // a lone waypoint: just before it, on it, and at time zero
   task automatic test_single_waypoint();
      write_origin(CSR_START_X, FIX_MAX);
      write_origin(CSR_START_Y, '0);
      send_word(KIND_APPEND, 10'd1023, 10'd0, 3'd7, 32'd1000);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd999);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd1000);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd0);
   endtask

   // segment 0 runs from the start point; heading flips at the half time
   task automatic test_first_segment();
      send_word(KIND_APPEND, 10'd0, 10'd1023, 3'd2, 32'd1010);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd1000);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd1004);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd1005);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd1009);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd1010);
   endtask

   // a time behind the remembered segment misses and resets the search
   task automatic test_behind_segment();
      send_word(KIND_APPEND, 10'd512, 10'd512, 3'd5, TIME_MAX);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd1005);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'h8000_0000);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'hFFFF_FFFE);
      send_word(KIND_QUERY_HI, 10'd0, 10'd0, 3'd0, 32'd1005);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd1005);
   endtask

   task automatic test_clear();
      send_word(KIND_CLEAR, 10'd0, 10'd0, 3'd0, 32'd0);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, 32'd5);
   endtask

   // fill the table, overflow it, then query up to the last segment
   task automatic test_full_table();
      write_origin(CSR_START_X, '0);
      write_origin(CSR_START_Y, FIX_MAX);
      run_track(MAX_WP + 2, 60, 1'b1);
      send_word(KIND_QUERY, 10'd0, 10'd0, 3'd0, TIME_MAX);
   endtask

   task automatic test_random_tracks();
      int points;
      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            write_origin(CSR_START_X, ($urandom_range(0, 3) == 0) ? FIX_MAX : $urandom);
            write_origin(CSR_START_Y, ($urandom_range(0, 3) == 0) ? '0 : $urandom);
         end
         steady_sender = ($urandom_range(0, 4) == 0);
         points = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
         run_track(points, $urandom_range(points, 3 * points + 6), 1'b0);
      end
      steady_sender = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_single_waypoint();
      test_first_segment();
      test_behind_segment();
      test_clear();
      test_full_table();
      test_random_tracks();
      settle_track();
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
